@@ sv/blr_pkg.sv @@
package blr_pkg;

	localparam int COORD_BITS = 10;
	localparam int LEN_BITS   = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 2;
	localparam int COLOR_BITS = 16;
	localparam int KIND_BITS  = 2;
	localparam int OP_BITS    = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0] mag_t;
	typedef logic [LEN_BITS-1:0] len_t;
	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [OP_BITS-1:0] op_t;

	// classified operation codes
	localparam op_t OP_STEP  = 2'd0;
	localparam op_t OP_HSPAN = 2'd1;
	localparam op_t OP_VSPAN = 2'd2;
	localparam op_t OP_LINE  = 2'd3;

	// result kind codes
	localparam kind_t KIND_PIXEL = 2'd0;
	localparam kind_t KIND_HSPAN = 2'd1;
	localparam kind_t KIND_VSPAN = 2'd2;

	localparam logic FUNC_START = 1'b0;

	// one classified command between front and back
	typedef struct packed {
		op_t    op;
		coord_t pos_x;
		coord_t pos_y;
		len_t   len;
		coord_t goal_x;
		coord_t goal_y;
		mag_t   delta_x;
		mag_t   delta_y;
		logic   dir_x_neg;
		logic   dir_y_neg;
		color_t color;
	} cmd_t;

	// queue read side towards the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

@@ sv/blr_front.sv @@
module blr_front (
	input  logic               func,
	input  blr_pkg::coord_t    start_x,
	input  blr_pkg::coord_t    start_y,
	input  blr_pkg::coord_t    end_x,
	input  blr_pkg::coord_t    end_y,
	input  blr_pkg::color_t    pixel_color,
	output blr_pkg::cmd_t      cmd
);

	localparam int CB = blr_pkg::COORD_BITS;

	logic signed [CB:0] diff_x, diff_y;
	logic signed [CB:0] abs_x, abs_y;
	blr_pkg::mag_t      mag_x, mag_y;
	logic               x_lt, y_lt;

	always_comb begin
		diff_x = $signed({start_x[CB-1], start_x}) - $signed({end_x[CB-1], end_x});
		diff_y = $signed({start_y[CB-1], start_y}) - $signed({end_y[CB-1], end_y});
		abs_x  = diff_x[CB] ? -diff_x : diff_x;
		abs_y  = diff_y[CB] ? -diff_y : diff_y;
		mag_x  = abs_x[CB-1:0];
		mag_y  = abs_y[CB-1:0];
		x_lt   = start_x < end_x;
		y_lt   = start_y < end_y;
	end

	always_comb begin
		cmd.goal_x    = end_x;
		cmd.goal_y    = end_y;
		cmd.delta_x   = mag_x;
		cmd.delta_y   = mag_y;
		cmd.dir_x_neg = !x_lt;
		cmd.dir_y_neg = !y_lt;
		cmd.color     = pixel_color;
		cmd.pos_x     = start_x;
		cmd.pos_y     = start_y;
		cmd.len       = blr_pkg::len_t'(1);
		if (func != blr_pkg::FUNC_START) begin
			cmd.op = blr_pkg::OP_STEP;
		end else if (start_y == end_y) begin
			// equal endpoints land here too, as a span of one
			cmd.op    = blr_pkg::OP_HSPAN;
			cmd.pos_x = x_lt ? start_x : end_x;
			cmd.len   = {1'b0, mag_x} + blr_pkg::len_t'(1);
		end else if (start_x == end_x) begin
			cmd.op    = blr_pkg::OP_VSPAN;
			cmd.pos_y = y_lt ? start_y : end_y;
			cmd.len   = {1'b0, mag_y} + blr_pkg::len_t'(1);
		end else begin
			cmd.op = blr_pkg::OP_LINE;
		end
	end

endmodule

@@ sv/blr_queue.sv @@
module blr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  blr_pkg::cmd_t     push_cmd,
	output logic              full,
	input  logic              pop,
	output blr_pkg::q_head_t  head
);

	localparam int DEPTH = blr_pkg::QUEUE_DEPTH;
	localparam int PB    = blr_pkg::QPTR_BITS;
	localparam int CB    = blr_pkg::QCNT_BITS;

	blr_pkg::cmd_t  slot_q [DEPTH];
	logic [PB-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CB-1:0]  count_q;
	logic           do_push, do_pop;

	function automatic logic [PB-1:0] ptr_inc(input logic [PB-1:0] p);
		return (p == PB'(DEPTH - 1)) ? '0 : p + PB'(1);
	endfunction

	assign full     = count_q == CB'(DEPTH);
	assign do_push  = push && !full;
	assign do_pop   = pop && (count_q != '0);
	assign head.valid = count_q != '0;
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CB'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CB'(1)))
		else $error("queue count missed a push");

endmodule

@@ sv/blr_back.sv @@
module blr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  blr_pkg::q_head_t   head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output blr_pkg::kind_t     kind,
	output blr_pkg::coord_t    out_x,
	output blr_pkg::coord_t    out_y,
	output blr_pkg::len_t      span_length,
	output blr_pkg::color_t    out_color,
	output logic               last
);

	localparam int CB = blr_pkg::COORD_BITS;
	localparam int EB = blr_pkg::ERR_BITS;

	// line walker state
	logic              busy_q;
	blr_pkg::coord_t   cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	blr_pkg::mag_t     dx_q, dy_q;
	blr_pkg::err_t     err_q;
	logic              dir_x_neg_q, dir_y_neg_q;
	blr_pkg::color_t   color_q;

	// result register
	logic              res_valid_q;
	blr_pkg::kind_t    res_kind_q;
	blr_pkg::coord_t   res_x_q, res_y_q;
	blr_pkg::len_t     res_len_q;
	blr_pkg::color_t   res_color_q;
	logic              res_last_q;

	logic                   advance, emits, is_step;
	logic signed [EB:0]     e2, neg_dy, dx_ext;
	logic                   move_x, move_y;
	blr_pkg::coord_t        nx, ny;
	blr_pkg::err_t          err_nxt;
	logic                   fin;

	assign advance = head.valid && (!res_valid_q || !out_stall);
	assign pop     = advance;
	assign is_step = head.cmd.op == blr_pkg::OP_STEP;
	assign emits   = !is_step || busy_q;

	always_comb begin
		e2      = $signed({err_q, 1'b0});
		neg_dy  = -$signed({3'b000, dy_q});
		dx_ext  = $signed({3'b000, dx_q});
		move_x  = e2 > neg_dy;
		move_y  = e2 < dx_ext;
		err_nxt = err_q;
		nx      = cur_x_q;
		ny      = cur_y_q;
		if (move_x) begin
			err_nxt = err_nxt - $signed({2'b00, dy_q});
			nx      = dir_x_neg_q ? cur_x_q - CB'(1) : cur_x_q + CB'(1);
		end
		if (move_y) begin
			err_nxt = err_nxt + $signed({2'b00, dx_q});
			ny      = dir_y_neg_q ? cur_y_q - CB'(1) : cur_y_q + CB'(1);
		end
		fin = (nx == goal_x_q) && (ny == goal_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				res_valid_q <= emits;
				case (head.cmd.op)
					blr_pkg::OP_STEP: begin
						if (busy_q && fin) begin
							busy_q <= 1'b0;
						end
					end
					blr_pkg::OP_LINE: busy_q <= 1'b1;
					default:          busy_q <= 1'b0;
				endcase
			end else if (res_valid_q && !out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			case (head.cmd.op)
				blr_pkg::OP_STEP: begin
					if (busy_q) begin
						cur_x_q     <= nx;
						cur_y_q     <= ny;
						err_q       <= err_nxt;
						res_kind_q  <= blr_pkg::KIND_PIXEL;
						res_x_q     <= nx;
						res_y_q     <= ny;
						res_len_q   <= blr_pkg::len_t'(1);
						res_color_q <= color_q;
						res_last_q  <= fin;
					end
				end
				blr_pkg::OP_LINE: begin
					cur_x_q     <= head.cmd.pos_x;
					cur_y_q     <= head.cmd.pos_y;
					goal_x_q    <= head.cmd.goal_x;
					goal_y_q    <= head.cmd.goal_y;
					dx_q        <= head.cmd.delta_x;
					dy_q        <= head.cmd.delta_y;
					dir_x_neg_q <= head.cmd.dir_x_neg;
					dir_y_neg_q <= head.cmd.dir_y_neg;
					err_q       <= $signed({2'b00, head.cmd.delta_x})
						- $signed({2'b00, head.cmd.delta_y});
					color_q     <= head.cmd.color;
					res_kind_q  <= blr_pkg::KIND_PIXEL;
					res_x_q     <= head.cmd.pos_x;
					res_y_q     <= head.cmd.pos_y;
					res_len_q   <= blr_pkg::len_t'(1);
					res_color_q <= head.cmd.color;
					res_last_q  <= 1'b0;
				end
				default: begin
					color_q     <= head.cmd.color;
					res_kind_q  <= (head.cmd.op == blr_pkg::OP_HSPAN)
						? blr_pkg::KIND_HSPAN : blr_pkg::KIND_VSPAN;
					res_x_q     <= head.cmd.pos_x;
					res_y_q     <= head.cmd.pos_y;
					res_len_q   <= head.cmd.len;
					res_color_q <= head.cmd.color;
					res_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid   = res_valid_q;
	assign kind        = res_kind_q;
	assign out_x       = res_x_q;
	assign out_y       = res_y_q;
	assign span_length = res_len_q;
	assign out_color   = res_color_q;
	assign last        = res_last_q;

	a_span_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q != blr_pkg::KIND_PIXEL) |-> res_last_q)
		else $error("span result without last");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q) |-> !busy_q)
		else $error("engine still busy after last result");

	a_last_at_goal: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q && res_kind_q == blr_pkg::KIND_PIXEL)
		|-> (res_x_q == goal_x_q && res_y_q == goal_y_q))
		else $error("last pixel not at far endpoint");

endmodule

@@ sv/bresenham_line_raster_core.sv @@
// Bresenham line rasterizer. A start transaction (func 0) carries two endpoints and
// a color: a horizontal line (equal y, including a single point) gives one horizontal
// span from the smaller x, a vertical line one vertical span from the smaller y, both
// flagged last; any other line gives its first endpoint as a pixel and arms the walker.
// Each step transaction (func 1) then gives the next pixel, and the one at the far
// endpoint is flagged last, after which steps give nothing until the next start. A
// start while a line runs abandons it. The front end classifies each transaction and
// computes spans and deltas in the cycle it is accepted, a two entry queue holds it,
// and the walker retires one command a clock into the result register, so up to one
// result per clock leaves while out_stall stays low. With the queue empty, a command
// is registered in a queue slot and then its result in the result register.
module bresenham_line_raster_core (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  blr_pkg::coord_t   start_x,
	input  blr_pkg::coord_t   start_y,
	input  blr_pkg::coord_t   end_x,
	input  blr_pkg::coord_t   end_y,
	input  blr_pkg::color_t   pixel_color,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output blr_pkg::kind_t    kind,
	output blr_pkg::coord_t   out_x,
	output blr_pkg::coord_t   out_y,
	output blr_pkg::len_t     span_length,
	output blr_pkg::color_t   out_color,
	output logic              last
);

	blr_pkg::cmd_t     front_cmd;
	blr_pkg::q_head_t  q_head;
	logic              q_full;
	logic              q_pop;

	// stall only on a full queue, so it never looks at in_valid
	assign in_stall = q_full;

	// classify and precompute span start, length and deltas
	blr_front u_front (
		.func        (func),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_color (pixel_color),
		.cmd         (front_cmd)
	);

	// decouples acceptance from result back pressure
	blr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	// line walker and result register
	blr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_x       (out_x),
		.out_y       (out_y),
		.span_length (span_length),
		.out_color   (out_color),
		.last        (last)
	);

endmodule
